// ----- rtl/core/gfb_pkg.sv -----
// Shared types, constants and helpers for the grid feature binner.
// No dependencies.
package gfb_pkg;

  localparam int unsigned GridCells = 256;
  localparam int unsigned ZoneCount = 16;
  localparam int unsigned CoordBits = 12;
  localparam int unsigned CellIdxW  = $clog2(GridCells);
  localparam int unsigned ZoneIdxW  = $clog2(ZoneCount);
  localparam int unsigned DimW      = 13;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [15:0] ThrReset = 16'd17920;
  localparam logic [15:0] ThrHigh  = 16'd64000;
  localparam logic [15:0] ThrLow   = 16'd2560;
  localparam logic [12:0] StepGain = 13'd6554;
  localparam logic [8:0]  CountMax = 9'd511;

  localparam logic [2:0] RegFrameW = 3'd0;
  localparam logic [2:0] RegFrameH = 3'd1;
  localparam logic [2:0] RegCellW  = 3'd2;
  localparam logic [2:0] RegCellH  = 3'd3;
  localparam logic [2:0] RegZoneW  = 3'd4;
  localparam logic [2:0] RegZoneH  = 3'd5;
  localparam logic [2:0] RegMinLd  = 3'd6;
  localparam logic [2:0] RegTarget = 3'd7;

  typedef enum logic [2:0] {
    ModeFeature = 3'd0,
    ModePropagate = 3'd1,
    ModeZoneQuery = 3'd2,
    ModeZoneUpdate = 3'd3,
    ModeCellRead = 3'd4,
    ModeClear = 3'd5,
    ModeBad6 = 3'd6,
    ModeBad7 = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    StDone = 2'd0,
    StOutOfBounds = 2'd1,
    StRejected = 2'd2,
    StSpare = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FeIdle, FeDivCx, FeDivCy, FeDivZx, FeDivZy, FeIdx, FePush
  } fe_state_e;

  typedef enum logic [1:0] {
    BeIdle, BeRead, BeExec, BeClear
  } be_state_e;

  // classified command handed from front to back
  typedef struct packed {
    mode_e                  mode;
    logic                   bad;
    logic [CoordBits-1:0]   pos_x;
    logic [CoordBits-1:0]   pos_y;
    logic [15:0]            strength;
    logic [CellIdxW-1:0]    cell_idx;
    logic                   zone_ok;
    logic [ZoneIdxW-1:0]    zone;
    logic                   found_gt;
  } cmd_t;

  typedef struct packed {
    logic [DimW-1:0] frame_w;
    logic [DimW-1:0] frame_h;
    logic [DimW-1:0] cell_w;
    logic [DimW-1:0] cell_h;
    logic [DimW-1:0] zone_w;
    logic [DimW-1:0] zone_h;
    logic [8:0]      min_load;
    logic [15:0]     target;
  } cfg_t;

  typedef struct packed {
    status_e              status;
    logic [CoordBits-1:0] cell_x;
    logic [CoordBits-1:0] cell_y;
    logic [15:0]          cell_strength;
    logic                 cell_filled;
    logic                 cell_locked;
    logic [7:0]           zone_threshold;
    logic                 detect_enable;
    logic [8:0]           zone_count;
  } result_t;

endpackage

// ----- rtl/core/gfb_divider.sv -----
// Restoring divider, one quotient bit per cycle, 13-bit operands.
// Depends on gfb_pkg.
module gfb_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [gfb_pkg::DimW-1:0] dividend_i,
  input  logic [gfb_pkg::DimW-1:0] divisor_i,
  output logic [gfb_pkg::DimW-1:0] quotient_o
);
  localparam int unsigned W = gfb_pkg::DimW;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [W:0]      trial;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; cnt_d = cnt_q; busy_d = busy_q;
    trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};
    if (start_i) begin
      rem_d = '0; quo_d = dividend_i;
      dvs_d = (divisor_i == '0) ? W'(1) : divisor_i;
      cnt_d = CntW'(W); busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
endmodule

// ----- rtl/core/gfb_front.sv -----
// Front end: accepts input beats, maps points to cell and zone indices.
// Depends on gfb_pkg and gfb_divider.
module gfb_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gfb_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           mode_i,
  input  logic [gfb_pkg::CoordBits-1:0] pos_x_i,
  input  logic [gfb_pkg::CoordBits-1:0] pos_y_i,
  input  logic [15:0]          strength_i,
  input  logic [7:0]           slot_i,
  input  logic [15:0]          found_count_i,
  output logic                 push_o,
  output gfb_pkg::cmd_t        cmd_o,
  input  logic                 full_i
);
  localparam int unsigned W = gfb_pkg::DimW;
  localparam int unsigned CW = gfb_pkg::CellIdxW;
  localparam int unsigned ZW = gfb_pkg::ZoneIdxW;
  localparam int unsigned PadW = W - gfb_pkg::CoordBits;

  gfb_pkg::fe_state_e state_q, state_d;
  gfb_pkg::cmd_t      cmd_q, cmd_d;
  logic [W-1:0] cols_c_q, rows_c_q, cx_q, cy_q, cols_z_q, rows_z_q, zx_q, zy_q;
  logic         sub_q, sub_d;

  logic         div_start;
  logic [W-1:0] div_a, div_b, div_quo;
  logic [4:0]   div_cnt_q, div_cnt_d;

  gfb_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .quotient_o(div_quo)
  );

  logic [2*W-1:0] cell_prod, zone_prod;
  logic [W-1:0]   px, py;
  logic           oob_pt;

  assign px = {{PadW{1'b0}}, cmd_q.pos_x};
  assign py = {{PadW{1'b0}}, cmd_q.pos_y};
  assign oob_pt = (px >= cfg_i.frame_w) || (py >= cfg_i.frame_h);
  assign cell_prod = cy_q * cols_c_q + {{W{1'b0}}, cx_q};
  assign zone_prod = zy_q * cols_z_q + {{W{1'b0}}, zx_q};

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; sub_d = sub_q; div_cnt_d = div_cnt_q;
    div_start = 1'b0; div_a = cfg_i.frame_w; div_b = cfg_i.cell_w;
    in_ready_o = (state_q == gfb_pkg::FeIdle);
    push_o = 1'b0;
    case (state_q)
      gfb_pkg::FeDivCx: begin div_a = sub_q ? px : cfg_i.frame_w; div_b = cfg_i.cell_w; end
      gfb_pkg::FeDivCy: begin div_a = sub_q ? py : cfg_i.frame_h; div_b = cfg_i.cell_h; end
      gfb_pkg::FeDivZx: begin div_a = sub_q ? px : cfg_i.frame_w; div_b = cfg_i.zone_w; end
      gfb_pkg::FeDivZy: begin div_a = sub_q ? py : cfg_i.frame_h; div_b = cfg_i.zone_h; end
      default: ;
    endcase
    case (state_q)
      gfb_pkg::FeIdle: begin
        if (in_valid_i) begin
          cmd_d.mode     = gfb_pkg::mode_e'(mode_i);
          cmd_d.pos_x    = pos_x_i;
          cmd_d.pos_y    = pos_y_i;
          cmd_d.strength = strength_i;
          cmd_d.found_gt = found_count_i > cfg_i.target;
          cmd_d.zone_ok  = 1'b0;
          cmd_d.bad      = 1'b0;
          cmd_d.cell_idx = slot_i[CW-1:0];
          cmd_d.zone     = slot_i[ZW-1:0];
          if (mode_i == gfb_pkg::ModeFeature || mode_i == gfb_pkg::ModePropagate) begin
            state_d = gfb_pkg::FeDivCx; sub_d = 1'b0; div_cnt_d = '0;
          end else begin
            if (mode_i == gfb_pkg::ModeZoneQuery || mode_i == gfb_pkg::ModeZoneUpdate)
              cmd_d.bad = {24'd0, slot_i} >= 32'(gfb_pkg::ZoneCount);
            else if (mode_i == gfb_pkg::ModeCellRead)
              cmd_d.bad = {24'd0, slot_i} >= 32'(gfb_pkg::GridCells);
            else if (mode_i == gfb_pkg::ModeBad6 || mode_i == gfb_pkg::ModeBad7)
              cmd_d.bad = 1'b1;
            state_d = gfb_pkg::FePush;
          end
        end
      end
      gfb_pkg::FeDivCx, gfb_pkg::FeDivCy, gfb_pkg::FeDivZx, gfb_pkg::FeDivZy: begin
        if (div_cnt_q == '0) div_start = 1'b1;
        div_cnt_d = div_cnt_q + 5'd1;
        if (div_cnt_q == 5'(W + 1)) begin
          div_cnt_d = '0;
          sub_d = !sub_q;
          if (sub_q) begin
            if (state_q == gfb_pkg::FeDivCx) state_d = gfb_pkg::FeDivCy;
            else if (state_q == gfb_pkg::FeDivCy) state_d = gfb_pkg::FeDivZx;
            else if (state_q == gfb_pkg::FeDivZx) state_d = gfb_pkg::FeDivZy;
            else state_d = gfb_pkg::FeIdx;
          end
        end
      end
      gfb_pkg::FeIdx: begin
        cmd_d.bad = oob_pt || (cx_q >= cols_c_q) || (cy_q >= rows_c_q) ||
                    (cell_prod >= (2*W)'(gfb_pkg::GridCells));
        cmd_d.cell_idx = cell_prod[CW-1:0];
        cmd_d.zone_ok = !oob_pt && (zx_q < cols_z_q) && (zy_q < rows_z_q) &&
                        (zone_prod < (2*W)'(gfb_pkg::ZoneCount));
        cmd_d.zone = zone_prod[ZW-1:0];
        state_d = gfb_pkg::FePush;
      end
      gfb_pkg::FePush: begin
        if (!full_i) begin
          push_o = 1'b1;
          state_d = gfb_pkg::FeIdle;
        end
      end
      default: state_d = gfb_pkg::FeIdle;
    endcase
  end

  assign cmd_o = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gfb_pkg::FeIdle; sub_q <= 1'b0; div_cnt_q <= '0;
    end else begin
      state_q <= state_d; sub_q <= sub_d; div_cnt_q <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (div_cnt_q == 5'(W + 1)) begin
      case (state_q)
        gfb_pkg::FeDivCx: if (sub_q) cx_q <= div_quo; else cols_c_q <= div_quo;
        gfb_pkg::FeDivCy: if (sub_q) cy_q <= div_quo; else rows_c_q <= div_quo;
        gfb_pkg::FeDivZx: if (sub_q) zx_q <= div_quo; else cols_z_q <= div_quo;
        gfb_pkg::FeDivZy: if (sub_q) zy_q <= div_quo; else rows_z_q <= div_quo;
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> state_q == gfb_pkg::FePush) else $error("push outside push state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> state_q == gfb_pkg::FeIdle) else $error("front did not return idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("front took two beats");
endmodule

// ----- rtl/core/gfb_back.sv -----
// Back end: command queue, grid and zone stores, result register.
// Depends on gfb_pkg.
module gfb_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gfb_pkg::cfg_t   cfg_i,
  input  logic            push_i,
  input  gfb_pkg::cmd_t   cmd_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output gfb_pkg::result_t res_o
);
  localparam int unsigned CB = gfb_pkg::CoordBits;
  localparam int unsigned NG = gfb_pkg::GridCells;
  localparam int unsigned NZ = gfb_pkg::ZoneCount;
  localparam int unsigned PW = gfb_pkg::QueuePtrW;
  localparam int unsigned QW = gfb_pkg::QueueCntW;

  gfb_pkg::cmd_t fifo_q [gfb_pkg::QueueDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [QW-1:0] cnt_q;
  logic          pop;

  gfb_pkg::be_state_e state_q, state_d;
  gfb_pkg::cmd_t   cur_q;
  gfb_pkg::result_t res_q, res_d;
  logic            ov_q, ov_d;

  logic [CB-1:0] mem_x [NG];
  logic [CB-1:0] mem_y [NG];
  logic [15:0]   mem_s [NG];
  logic [CB-1:0] rd_x_q, rd_y_q;
  logic [15:0]   rd_s_q;
  logic [NG-1:0] filled_q, locked_q;
  logic [15:0]   thr_q [NZ];
  logic [8:0]    zcnt_q [NZ];

  logic          mem_we, fill_set, lock_set, zinc, thr_we, clr;
  logic [15:0]   wr_s;
  logic [15:0]   thr_new;
  logic [16:0]   diff;
  logic [16:0]   mag;
  logic [29:0]   prod;
  logic [8:0]    zc;

  assign full_o = (cnt_q == QW'(gfb_pkg::QueueDepth));
  assign pop = (state_q == gfb_pkg::BeIdle) && (cnt_q != '0) && !ov_q;

  always_comb begin
    diff = (cur_q.found_gt ? {1'b0, gfb_pkg::ThrHigh} : {1'b0, gfb_pkg::ThrLow})
           - {1'b0, thr_q[cur_q.zone]};
    mag  = diff[16] ? (~diff + 17'd1) : diff;
    prod = mag * gfb_pkg::StepGain;
    if (diff[16]) thr_new = thr_q[cur_q.zone] - 16'((prod + 30'd65535) >> 16);
    else thr_new = thr_q[cur_q.zone] + 16'(prod >> 16);
  end

  always_comb begin
    state_d = state_q; res_d = res_q; ov_d = ov_q;
    mem_we = 1'b0; fill_set = 1'b0; lock_set = 1'b0; zinc = 1'b0; thr_we = 1'b0;
    clr = 1'b0; wr_s = cur_q.strength; zc = zcnt_q[cur_q.zone];
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      gfb_pkg::BeIdle: if (pop) state_d = gfb_pkg::BeRead;
      gfb_pkg::BeRead: state_d = gfb_pkg::BeExec;
      gfb_pkg::BeExec: begin
        res_d = '0;
        ov_d = 1'b1;
        state_d = gfb_pkg::BeIdle;
        if (cur_q.bad) begin
          res_d.status = gfb_pkg::StOutOfBounds;
        end else begin
          case (cur_q.mode)
            gfb_pkg::ModeFeature: begin
              if (!filled_q[cur_q.cell_idx] ||
                  (!locked_q[cur_q.cell_idx] && rd_s_q < cur_q.strength)) begin
                mem_we = 1'b1; fill_set = 1'b1;
              end else res_d.status = gfb_pkg::StRejected;
            end
            gfb_pkg::ModePropagate: begin
              if (filled_q[cur_q.cell_idx]) res_d.status = gfb_pkg::StRejected;
              else begin
                mem_we = 1'b1; fill_set = 1'b1; lock_set = 1'b1; wr_s = 16'd1;
                zinc = cur_q.zone_ok && (zcnt_q[cur_q.zone] < gfb_pkg::CountMax);
              end
            end
            gfb_pkg::ModeZoneQuery, gfb_pkg::ModeZoneUpdate: begin
              thr_we = (cur_q.mode == gfb_pkg::ModeZoneUpdate);
              res_d.zone_threshold = thr_we ? thr_new[15:8] : thr_q[cur_q.zone][15:8];
              res_d.detect_enable = zc <= cfg_i.min_load;
              res_d.zone_count = zc;
            end
            gfb_pkg::ModeCellRead: begin
              if (filled_q[cur_q.cell_idx]) begin
                res_d.cell_x = rd_x_q; res_d.cell_y = rd_y_q;
                res_d.cell_strength = rd_s_q; res_d.cell_filled = 1'b1;
              end
              res_d.cell_locked = locked_q[cur_q.cell_idx];
            end
            gfb_pkg::ModeClear: clr = 1'b1;
            default: res_d.status = gfb_pkg::StOutOfBounds;
          endcase
        end
      end
      default: state_d = gfb_pkg::BeIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
      state_q <= gfb_pkg::BeIdle; ov_q <= 1'b0;
      filled_q <= '0; locked_q <= '0;
      for (int i = 0; i < NZ; i++) begin
        thr_q[i] <= gfb_pkg::ThrReset; zcnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d; ov_q <= ov_d;
      if (push_i) wp_q <= (wp_q == PW'(gfb_pkg::QueueDepth - 1)) ? '0 : wp_q + PW'(1);
      if (pop) rp_q <= (rp_q == PW'(gfb_pkg::QueueDepth - 1)) ? '0 : rp_q + PW'(1);
      cnt_q <= cnt_q + QW'(push_i) - QW'(pop);
      if (clr) begin
        filled_q <= '0; locked_q <= '0;
        for (int i = 0; i < NZ; i++) zcnt_q[i] <= '0;
      end
      if (fill_set) filled_q[cur_q.cell_idx] <= 1'b1;
      if (lock_set) locked_q[cur_q.cell_idx] <= 1'b1;
      if (zinc) zcnt_q[cur_q.zone] <= zc + 9'd1;
      if (thr_we) thr_q[cur_q.zone] <= thr_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) fifo_q[wp_q] <= cmd_i;
    if (pop) cur_q <= fifo_q[rp_q];
    if (state_q == gfb_pkg::BeExec) res_q <= res_d;
    if (state_q == gfb_pkg::BeRead) begin
      rd_x_q <= mem_x[cur_q.cell_idx]; rd_y_q <= mem_y[cur_q.cell_idx];
      rd_s_q <= mem_s[cur_q.cell_idx];
    end
    if (mem_we) begin
      mem_x[cur_q.cell_idx] <= cur_q.pos_x; mem_y[cur_q.cell_idx] <= cur_q.pos_y;
      mem_s[cur_q.cell_idx] <= wr_s;
    end
  end

  assign out_valid_o = ov_q;
  assign res_o = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QW'(gfb_pkg::QueueDepth)) else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gfb_pkg::BeExec) |-> !ov_q) else $error("result overwritten");
endmodule

// ----- rtl/core/grid_feature_binner_unit.sv -----
// Top level of the grid feature binner: configuration registers, front and back.
// Depends on gfb_pkg, gfb_front, gfb_back.
//
// Each beat carries one command and returns exactly one result beat. Point
// commands (feature, propagate) hold the front for eight 13-bit bit-serial
// divisions (grid and zone columns, rows and coordinates) through one shared
// divider, plus the accept, index and push steps. Other commands pass through
// the front's accept and push states only. The back end reads, then executes
// each command, and waits for the result beat to be taken before it starts
// the next one; a two-entry queue lets both ends stall apart.
module grid_feature_binner_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode[2:0], pos_x[14:3], pos_y[26:15], strength[42:27], slot[50:43],
  // found_count[66:51], zero pad to 72
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], cell_x[13:2], cell_y[25:14], cell_strength[41:26],
  // cell_filled[42], cell_locked[43], zone_threshold[51:44],
  // detect_enable[52], zone_count[61:53], zero pad to 64
  output logic [63:0] m_axis_tdata
);
  gfb_pkg::cfg_t    cfg_q;
  gfb_pkg::cmd_t    cmd;
  gfb_pkg::result_t res;
  logic             push, full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_w <= 13'd640; cfg_q.frame_h <= 13'd480;
      cfg_q.cell_w <= 13'd40; cfg_q.cell_h <= 13'd30;
      cfg_q.zone_w <= 13'd160; cfg_q.zone_h <= 13'd120;
      cfg_q.min_load <= 9'd0; cfg_q.target <= 16'd1000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gfb_pkg::RegFrameW: cfg_q.frame_w <= cfg_data_i[12:0];
        gfb_pkg::RegFrameH: cfg_q.frame_h <= cfg_data_i[12:0];
        gfb_pkg::RegCellW:  cfg_q.cell_w <= cfg_data_i[12:0];
        gfb_pkg::RegCellH:  cfg_q.cell_h <= cfg_data_i[12:0];
        gfb_pkg::RegZoneW:  cfg_q.zone_w <= cfg_data_i[12:0];
        gfb_pkg::RegZoneH:  cfg_q.zone_h <= cfg_data_i[12:0];
        gfb_pkg::RegMinLd:  cfg_q.min_load <= cfg_data_i[8:0];
        gfb_pkg::RegTarget: cfg_q.target <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gfb_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .mode_i(s_axis_tdata[2:0]), .pos_x_i(s_axis_tdata[14:3]),
    .pos_y_i(s_axis_tdata[26:15]), .strength_i(s_axis_tdata[42:27]),
    .slot_i(s_axis_tdata[50:43]), .found_count_i(s_axis_tdata[66:51]),
    .push_o(push), .cmd_o(cmd), .full_i(full)
  );

  gfb_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .push_i(push), .cmd_i(cmd), .full_o(full),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {2'b00, res.zone_count, res.detect_enable, res.zone_threshold,
                         res.cell_locked, res.cell_filled, res.cell_strength,
                         res.cell_y, res.cell_x, res.status};
endmodule
